// ===== hw/rtl/integer_text_to_int64_parser_macros.svh =====
// Assertion helpers for the checker file.
`ifndef INTEGER_TEXT_TO_INT64_PARSER_MACROS_SVH
`define INTEGER_TEXT_TO_INT64_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define T2I_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define T2I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define T2I_ASSERT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/txt2i64_pkg.sv =====
package txt2i64_pkg;

  localparam int unsigned MAX_STRING = 65535;
  localparam logic [16:0] CNT_CAP =
    17'((MAX_STRING < 65535) ? MAX_STRING : 65535);

  localparam int unsigned QDEPTH = 2;

  // Digit code for a byte that is neither 0-9 nor a letter.
  localparam logic [5:0] DIGIT_NONE = 6'd63;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_MAX   = 6'd36;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_INV = 2'd2;

  localparam logic REG_RADIX  = 1'b0;
  localparam logic REG_SIGNED = 1'b1;

  localparam logic [63:0] S64_POS_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_NEG_SAT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] U64_SAT     = 64'hFFFF_FFFF_FFFF_FFFF;

  // One classified character as it waits in the queue.
  typedef struct packed {
    logic       last;
    logic       ws;
    logic       sign;
    logic       minus;
    logic       zero;
    logic       x;
    logic [5:0] digit;
  } cls_t;

  // Snapshot of a finished string, handed to the result stage.
  typedef struct packed {
    logic [63:0] acc;
    logic        ovf;
    logic        minus;
    logic        inv;
    logic        sgn;
    logic [15:0] cnt;
  } res_t;

endpackage

// ===== hw/rtl/txt2i64_front.sv =====
module txt2i64_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_character,
  input  logic                in_last,
  output logic                q_valid,
  output txt2i64_pkg::cls_t   q_item,
  input  logic                q_pop
);

  localparam int PW = (txt2i64_pkg::QDEPTH > 1) ? $clog2(txt2i64_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(txt2i64_pkg::QDEPTH + 1);

  txt2i64_pkg::cls_t q_mem_r [txt2i64_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  txt2i64_pkg::cls_t cls;
  logic [7:0]        lc;
  logic              push;

  always_comb begin
    lc        = in_character | 8'h20;
    cls.last  = in_last;
    cls.ws    = (in_character == 8'd32) ||
                ((in_character >= 8'd9) && (in_character <= 8'd13));
    cls.sign  = (in_character == 8'h2B) || (in_character == 8'h2D);
    cls.minus = (in_character == 8'h2D);
    cls.zero  = (in_character == 8'h30);
    cls.x     = (lc == 8'h78);
    if ((in_character >= 8'h30) && (in_character <= 8'h39)) begin
      cls.digit = 6'(in_character - 8'h30);
    end else if ((lc >= 8'h61) && (lc <= 8'h7A)) begin
      cls.digit = 6'(lc - 8'h61 + 8'd10);
    end else begin
      cls.digit = txt2i64_pkg::DIGIT_NONE;
    end
  end

  assign in_ready = (cnt_r != CW'(txt2i64_pkg::QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(txt2i64_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(txt2i64_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/txt2i64_back.sv =====
module txt2i64_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [5:0]        radix,
  input  logic              signed_mode,
  input  logic              q_valid,
  input  txt2i64_pkg::cls_t q_item,
  output logic              q_pop,
  input  logic              res_ready,
  output logic              res_valid,
  output txt2i64_pkg::res_t res
);

  typedef enum logic [2:0] {
    PH_WS,
    PH_START,
    PH_DIGITS,
    PH_XSEEN,
    PH_STOPPED
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        minus_r, minus_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [5:0]  base_r, base_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic        zp_r, zp_nxt;

  logic [5:0]  v;
  logic        start_inv, start_zero, enter_start;
  logic [5:0]  start_base, mul_base, eff_base;
  logic [69:0] prod;
  logic [70:0] sum;
  logic [63:0] dig_acc;
  logic        dig_ovf;
  logic [16:0] t1, t2;
  logic [15:0] cnt_inc1, cnt_inc2;

  assign q_pop     = q_valid && (!q_item.last || res_ready);
  assign res_valid = q_pop && q_item.last;

  always_comb begin
    v          = q_item.digit;
    start_inv  = (radix == 6'd1) || (radix > txt2i64_pkg::BASE_MAX);
    start_zero = ((radix == 6'd0) || (radix == txt2i64_pkg::BASE_HEX)) && q_item.zero;
    start_base = (radix == 6'd0) ? txt2i64_pkg::BASE_DEC : radix;

    case (phase_r)
      PH_DIGITS: mul_base = base_r;
      PH_XSEEN:  mul_base = txt2i64_pkg::BASE_HEX;
      default:   mul_base = start_base;
    endcase

    // acc * base + digit overflows exactly when the bits above 63 are set.
    prod    = 70'(acc_r) * 70'(mul_base);
    sum     = 71'(prod) + 71'(v);
    dig_ovf = ovf_r || (sum[70:64] != '0);
    dig_acc = ovf_r ? acc_r : sum[63:0];

    t1       = 17'(cnt_r) + 17'd1;
    t2       = 17'(cnt_r) + 17'd2;
    cnt_inc1 = (t1 > txt2i64_pkg::CNT_CAP) ? txt2i64_pkg::CNT_CAP[15:0] : t1[15:0];
    cnt_inc2 = (t2 > txt2i64_pkg::CNT_CAP) ? txt2i64_pkg::CNT_CAP[15:0] : t2[15:0];

    phase_nxt = phase_r;
    minus_nxt = minus_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    zp_nxt    = zp_r;
    enter_start = 1'b0;

    case (phase_r)
      PH_WS: begin
        if (q_item.ws) begin
          cnt_nxt = cnt_inc1;
        end else if (q_item.sign) begin
          minus_nxt = q_item.minus;
          cnt_nxt   = cnt_inc1;
          phase_nxt = PH_START;
        end else begin
          enter_start = 1'b1;
        end
      end
      PH_START: begin
        enter_start = 1'b1;
      end
      PH_DIGITS: begin
        zp_nxt = 1'b0;
        if (zp_r && q_item.x) begin
          phase_nxt = PH_XSEEN;
        end else if (v < base_r) begin
          acc_nxt = dig_acc;
          ovf_nxt = dig_ovf;
          cnt_nxt = cnt_inc1;
        end else begin
          phase_nxt = PH_STOPPED;
        end
      end
      PH_XSEEN: begin
        // The x counts only once a hex digit follows it.
        if (v < txt2i64_pkg::BASE_HEX) begin
          base_nxt  = txt2i64_pkg::BASE_HEX;
          acc_nxt   = dig_acc;
          ovf_nxt   = dig_ovf;
          cnt_nxt   = cnt_inc2;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_STOPPED;
        end
      end
      default: begin
      end
    endcase

    if (enter_start) begin
      if (start_inv) begin
        base_nxt  = radix;
        cnt_nxt   = '0;
        phase_nxt = PH_STOPPED;
      end else if (start_zero) begin
        base_nxt  = (radix == 6'd0) ? txt2i64_pkg::BASE_OCT : txt2i64_pkg::BASE_HEX;
        zp_nxt    = 1'b1;
        acc_nxt   = '0;
        cnt_nxt   = cnt_inc1;
        phase_nxt = PH_DIGITS;
      end else begin
        base_nxt = start_base;
        if (v < start_base) begin
          acc_nxt   = dig_acc;
          ovf_nxt   = dig_ovf;
          cnt_nxt   = cnt_inc1;
          phase_nxt = PH_DIGITS;
        end else begin
          cnt_nxt   = '0;
          phase_nxt = PH_STOPPED;
        end
      end
    end

    eff_base  = (base_nxt != 6'd0) ? base_nxt : radix;
    res.acc   = acc_nxt;
    res.ovf   = ovf_nxt;
    res.minus = minus_nxt;
    res.inv   = (eff_base == 6'd1) || (eff_base > txt2i64_pkg::BASE_MAX);
    res.sgn   = signed_mode;
    res.cnt   = ((phase_nxt == PH_WS) || (phase_nxt == PH_START)) ? '0 : cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && q_item.last)) begin
      phase_r <= PH_WS;
      minus_r <= 1'b0;
      acc_r   <= '0;
      base_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      zp_r    <= 1'b0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      minus_r <= minus_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      zp_r    <= zp_nxt;
    end
  end

endmodule

// ===== hw/rtl/txt2i64_finish.sv =====
module txt2i64_finish (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  txt2i64_pkg::res_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_value,
  output logic [15:0]       out_consumed,
  output logic [1:0]        out_status
);

  logic              fin_valid_r;
  txt2i64_pkg::res_t fin_r;
  logic              out_valid_r;
  logic [63:0]       value_r, value_nxt;
  logic [15:0]       consumed_r, consumed_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_can;
  logic [63:0]       mag;
  logic              big;

  assign out_can   = !out_valid_r || out_ready;
  assign res_ready = !fin_valid_r || out_can;

  always_comb begin
    mag = fin_r.minus ? (64'd0 - fin_r.acc) : fin_r.acc;
    // Magnitude above the signed limit for the seen sign.
    big = fin_r.minus ? (fin_r.acc[63] && (fin_r.acc[62:0] != '0)) : fin_r.acc[63];
    value_nxt    = mag;
    consumed_nxt = fin_r.cnt;
    status_nxt   = txt2i64_pkg::ST_OK;
    if (fin_r.inv) begin
      value_nxt    = '0;
      consumed_nxt = '0;
      status_nxt   = txt2i64_pkg::ST_INV;
    end else if (fin_r.sgn) begin
      if (fin_r.ovf || big) begin
        value_nxt  = fin_r.minus ? txt2i64_pkg::S64_NEG_SAT : txt2i64_pkg::S64_POS_SAT;
        status_nxt = txt2i64_pkg::ST_OVF;
      end
    end else if (fin_r.ovf) begin
      value_nxt  = txt2i64_pkg::U64_SAT;
      status_nxt = txt2i64_pkg::ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_ready) begin
        fin_valid_r <= res_valid;
      end
      if (out_can) begin
        out_valid_r <= fin_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      fin_r <= res;
    end
    if (out_can && fin_valid_r) begin
      value_r    <= value_nxt;
      consumed_r <= consumed_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_consumed = consumed_r;
  assign out_status   = status_r;

endmodule

// ===== hw/rtl/integer_text_to_int64_parser.sv =====
// Channel   Ports                                         Moves
// in        in_valid/in_ready, in_character, in_last      one byte of a string
// out       out_valid/out_ready, out_value/consumed/status one result per last byte
// cfg       psel/penable/pwrite/paddr/pwdata/prdata        radix, signed_mode
//
// One byte is taken per cycle while the queue has room; the digit step (64x6 multiply, add,
// carry-out check) is the combinational loop that sets this rate.
// After its last byte is accepted, a result is registered in the finish stage, then in the output registers.
// Reset is synchronous and active low; it empties the queue and both result stages.
// A stalled output fills the result stages, then the two-entry queue, then drops in_ready.
module integer_text_to_int64_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic [15:0] out_consumed,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0]        radix_r;
  logic              sgn_r;
  logic              q_valid, q_pop;
  txt2i64_pkg::cls_t q_item;
  logic              res_valid, res_ready;
  txt2i64_pkg::res_t res;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= 6'd0;
      sgn_r   <= 1'b1;
    end else if (wr_en) begin
      case (paddr[2])
        txt2i64_pkg::REG_RADIX:  radix_r <= pwdata[5:0];
        txt2i64_pkg::REG_SIGNED: sgn_r   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      txt2i64_pkg::REG_RADIX:  prdata = {26'd0, radix_r};
      txt2i64_pkg::REG_SIGNED: prdata = {31'd0, sgn_r};
      default:                 prdata = '0;
    endcase
  end

  txt2i64_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_last      (in_last),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  txt2i64_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .radix       (radix_r),
    .signed_mode (sgn_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  txt2i64_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .out_status   (out_status)
  );

endmodule

// ===== hw/rtl/txt2i64_checker.sv =====
`include "integer_text_to_int64_parser_macros.svh"

module txt2i64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value,
  input logic [15:0] out_consumed,
  input logic [1:0]  out_status
);

  // A stalled result must hold until it is taken.
  `T2I_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_consumed) && $stable(out_status), "result changed while stalled")

  // An invalid base never reports a value or a count.
  `T2I_ASSERT_SAME(a_inv_zero, out_valid && (out_status == txt2i64_pkg::ST_INV), (out_value == 64'd0) && (out_consumed == 16'd0), "invalid base with nonzero result")

  // Saturation only ever lands on one of the three limits.
  `T2I_ASSERT_SAME(a_sat_value, out_valid && (out_status == txt2i64_pkg::ST_OVF), (out_value == txt2i64_pkg::S64_POS_SAT) || (out_value == txt2i64_pkg::S64_NEG_SAT) || (out_value == txt2i64_pkg::U64_SAT), "overflow with a value off the limits")

  // Reset leaves no result pending and the input open.
  `T2I_ASSERT_RAW(a_reset_empty, !rst_n, !out_valid && in_ready, "block not empty after reset")

endmodule

bind integer_text_to_int64_parser txt2i64_checker u_txt2i64_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [15:0] COUNT_CAP =
    16'((txt2i64_pkg::MAX_STRING < 65535) ? txt2i64_pkg::MAX_STRING : 65535);
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned HOLD_SPACING = 45;
  localparam int unsigned PHASE_BYTES = 105;
  localparam int unsigned BAD_PHASE_BYTES = 30;
  localparam int unsigned PICK_VALID = 100;
  localparam int unsigned PICK_INVALID = 101;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_LOW_A = "a";
  localparam logic [7:0] CH_LOW_Z = "z";
  localparam logic [7:0] CH_UP_A = "A";
  localparam logic [7:0] CH_LOW_X = "x";
  localparam logic [7:0] CH_UP_X = "X";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [2:0] {
    SCAN_BLANK, SCAN_SIGN_SEEN, SCAN_DIGITS, SCAN_AFTER_X, SCAN_DONE
  } scan_e;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] consumed;
    logic [1:0]  status;
  } number_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_character = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value;
  logic [15:0] out_consumed;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  integer_text_to_int64_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_character(in_character), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_consumed(out_consumed), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow of the parser: register copies and the state of the current string.
  logic [5:0]  cfg_radix = 6'd0;
  logic        cfg_signed = 1'b1;
  scan_e       sc_phase = SCAN_BLANK;
  logic        sc_minus = 1'b0;
  logic [63:0] sc_acc = 64'd0;
  logic [5:0]  sc_base = 6'd0;
  logic [15:0] sc_count = 16'd0;
  logic        sc_ovf = 1'b0;
  logic        sc_zero = 1'b0;

  number_t     expected_numbers[$];
  text_byte_t  pending_bytes[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned writes_done = 0;
  int unsigned holds_done = 0;

  int unsigned radix_plan[12] = '{0, 16, 10, 2, 8, 36, 1, PICK_VALID, 63, 16,
                                  PICK_INVALID, 0};

  function int unsigned digit_val(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (lc >= CH_LOW_A && lc <= CH_LOW_Z) return lc - CH_LOW_A + 10;
    return 99;
  endfunction

  function void count_one();
    if (sc_count < COUNT_CAP) sc_count = sc_count + 16'd1;
  endfunction

  function void accumulate(input int unsigned v);
    logic [63:0] b;
    logic [63:0] room;
    b = (sc_base >= 2) ? 64'(sc_base) : 64'd10;
    room = (txt2i64_pkg::U64_SAT - 64'(v)) / b;
    if (!sc_ovf) begin
      if (sc_acc > room) sc_ovf = 1'b1;
      else sc_acc = sc_acc * b + 64'(v);
    end
    count_one();
  endfunction

  // Stops the scan; if no digit was taken before the stop, nothing counts as consumed.
  function void halt();
    if (sc_phase == SCAN_BLANK || sc_phase == SCAN_SIGN_SEEN) sc_count = 16'd0;
    sc_phase = SCAN_DONE;
  endfunction

  function void clear_scan();
    sc_phase = SCAN_BLANK;
    sc_minus = 1'b0;
    sc_acc = 64'd0;
    sc_base = 6'd0;
    sc_count = 16'd0;
    sc_ovf = 1'b0;
    sc_zero = 1'b0;
  endfunction

  function void first_char(input logic [7:0] c);
    int unsigned v;
    logic [5:0]  b;
    if (cfg_radix == 6'd1 || cfg_radix > txt2i64_pkg::BASE_MAX) begin
      sc_base = cfg_radix;
      sc_phase = SCAN_DONE;
      sc_count = 16'd0;
      return;
    end
    if ((cfg_radix == 6'd0 || cfg_radix == txt2i64_pkg::BASE_HEX) && c == CH_ZERO) begin
      sc_base = (cfg_radix != 6'd0) ? txt2i64_pkg::BASE_HEX : txt2i64_pkg::BASE_OCT;
      sc_zero = 1'b1;
      sc_acc = 64'd0;
      count_one();
      sc_phase = SCAN_DIGITS;
      return;
    end
    b = (cfg_radix != 6'd0) ? cfg_radix : txt2i64_pkg::BASE_DEC;
    sc_base = b;
    v = digit_val(c);
    if (v < b) begin
      accumulate(v);
      sc_phase = SCAN_DIGITS;
    end else begin
      halt();
    end
  endfunction

  function void parse_char(input logic [7:0] c, input logic last);
    int unsigned v;
    logic [5:0]  eff;
    logic [63:0] lim;
    number_t     r;
    case (sc_phase)
      SCAN_BLANK: begin
        if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
          count_one();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          sc_minus = (c == CH_MINUS);
          count_one();
          sc_phase = SCAN_SIGN_SEEN;
        end else begin
          sc_phase = SCAN_SIGN_SEEN;
          first_char(c);
        end
      end
      SCAN_SIGN_SEEN: first_char(c);
      SCAN_DIGITS: begin
        if (sc_zero && (c | CASE_BIT) == CH_LOW_X) begin
          sc_zero = 1'b0;
          sc_phase = SCAN_AFTER_X;
        end else begin
          sc_zero = 1'b0;
          v = digit_val(c);
          if (v < sc_base) accumulate(v);
          else halt();
        end
      end
      SCAN_AFTER_X: begin
        v = digit_val(c);
        if (v < 16) begin
          sc_base = txt2i64_pkg::BASE_HEX;
          count_one();
          accumulate(v);
          sc_phase = SCAN_DIGITS;
        end else begin
          halt();
        end
      end
      default: ;
    endcase
    if (!last) return;

    r.value = 64'd0;
    r.consumed = 16'd0;
    r.status = txt2i64_pkg::ST_OK;
    eff = (sc_base != 6'd0) ? sc_base : cfg_radix;
    if (eff == 6'd1 || eff > txt2i64_pkg::BASE_MAX) begin
      r.status = txt2i64_pkg::ST_INV;
    end else begin
      r.consumed = (sc_phase == SCAN_BLANK || sc_phase == SCAN_SIGN_SEEN) ? 16'd0 : sc_count;
      if (cfg_signed) begin
        lim = sc_minus ? txt2i64_pkg::S64_NEG_SAT : txt2i64_pkg::S64_POS_SAT;
        if (sc_ovf || sc_acc > lim) begin
          r.value = lim;
          r.status = txt2i64_pkg::ST_OVF;
        end else begin
          r.value = sc_minus ? (64'd0 - sc_acc) : sc_acc;
        end
      end else if (sc_ovf) begin
        r.value = txt2i64_pkg::U64_SAT;
        r.status = txt2i64_pkg::ST_OVF;
      end else begin
        r.value = sc_minus ? (64'd0 - sc_acc) : sc_acc;
      end
    end
    expected_numbers.push_back(r);
    clear_scan();
  endfunction

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on result %0d: %s is %h, expected %h", results_seen, what, got, want);
    fail_count++;
  endtask

  // Request driver: bursts of random length with random gaps in between.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    text_byte_t nxt;
    logic       give;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_character <= 8'd0;
      in_last <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_character, in_last);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        give = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          give = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0: gap_left = $urandom_range(4, 12);
              1: gap_left = $urandom_range(1, 3);
              default: gap_left = 0;
            endcase
          end
        end
        in_valid <= give;
        if (give) begin
          in_character <= nxt.ch;
          in_last <= nxt.last;
        end
      end
    end
  end

  // Result monitor and the receiver's stall pattern.
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned next_hold = 20;
  rx_mode_e    rx_mode = RX_OPEN;
  logic [31:0] tick = 32'd0;

  always @(posedge clk) begin
    number_t want;
    logic    rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_numbers.size() == 0) begin
          report_mismatch("unexpected result, value", out_value, 64'd0);
        end else begin
          want = expected_numbers.pop_front();
          if (out_value !== want.value) report_mismatch("value", out_value, want.value);
          if (out_consumed !== want.consumed)
            report_mismatch("consumed", 64'(out_consumed), 64'(want.consumed));
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
        end
      end
      tick = tick + 32'd1;
      // Now and then hold off long enough for the block to back up into its input.
      if (hold_left == 0 && results_seen >= next_hold) begin
        hold_left = LONG_HOLD;
        next_hold += HOLD_SPACING;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN: rdy = 1'b1;
          RX_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
          RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = tick[2];
        endcase
      end
      out_ready <= rdy;
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no progress for %0d cycles, %0d results still due", quiet_cycles,
               expected_numbers.size());
      $display("** integer_text_to_int64_parser: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_byte(input logic [7:0] c, input logic last);
    text_byte_t t;
    t.ch = c;
    t.last = last;
    pending_bytes.push_back(t);
    bytes_queued++;
  endtask

  task send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
  endtask

  // Waits until every queued byte is taken and every result has come back.
  task settle();
    while (bytes_taken != bytes_queued || expected_numbers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == txt2i64_pkg::REG_RADIX) cfg_radix = val[5:0];
    else cfg_signed = val[0];
    writes_done++;
  endtask

  task set_mode(input int unsigned r, input logic s);
    write_reg(txt2i64_pkg::REG_RADIX, ($urandom & 32'hFFFF_FFC0) | 32'(r));
    write_reg(txt2i64_pkg::REG_SIGNED, ($urandom & 32'hFFFF_FFFE) | 32'(s));
  endtask

  // Mostly well-formed numbers with random content; the rest is plain noise.
  task add_random_string();
    logic [7:0]  s[$];
    int unsigned n;
    int unsigned b;
    int unsigned d;
    logic [7:0]  w;
    string       edge_num;
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          w = 8'($urandom_range(8, 13));
          s.push_back((w == 8'd8) ? CH_SPACE : w);
        end
      end
      case ($urandom_range(0, 3))
        0: s.push_back(CH_MINUS);
        1: s.push_back(CH_PLUS);
        default: ;
      endcase
      b = (cfg_radix >= 2 && cfg_radix <= txt2i64_pkg::BASE_MAX) ? cfg_radix : 10;
      if ((cfg_radix == 0 || cfg_radix == txt2i64_pkg::BASE_HEX) &&
          $urandom_range(0, 2) == 0) begin
        s.push_back(CH_ZERO);
        s.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
        b = 16;
      end else if (cfg_radix == 0 && $urandom_range(0, 3) == 0) begin
        s.push_back(CH_ZERO);
        b = 8;
      end
      if (b == 10 && $urandom_range(0, 4) == 0) begin
        // Values at and just past the signed and unsigned limits.
        case ($urandom_range(0, 3))
          0: edge_num = "9223372036854775807";
          1: edge_num = "9223372036854775808";
          2: edge_num = "18446744073709551615";
          default: edge_num = "18446744073709551616";
        endcase
        for (int i = 0; i < edge_num.len(); i++) s.push_back(edge_num[i]);
      end else begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 6);
        repeat (n) begin
          d = $urandom_range(0, b - 1);
          if (d < 10) s.push_back(CH_ZERO + 8'(d));
          else s.push_back(($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(d - 10));
        end
      end
      case ($urandom_range(0, 3))
        0: s.push_back(CH_NUL);
        1: s.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 2))
        s.push_back(8'($urandom_range(0, 255)));
    end
    if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  initial begin
    int unsigned r;
    int unsigned target;
    int unsigned start_count;
    logic        sg;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings under the reset settings: automatic base, signed.
    send_text("\t+0x1f", 1'b1);
    send_text("-017", 1'b1);
    send_text("0Xg", 1'b1);
    send_text("0x", 1'b1);
    for (int c = 9; c <= 13; c++) send_byte(8'(c), 1'b0);
    send_text(" -12", 1'b1);
    send_text(" z", 1'b1);
    send_byte(CH_NUL, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("7", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_text("5", 1'b1);
    settle();

    set_mode(36, 1'b0);
    send_text("-Zz", 1'b1);
    send_text("zzzzzzzzzzzzz", 1'b1);
    send_text("+", 1'b1);
    settle();
    set_mode(36, 1'b1);
    send_text("-zzzzzzzzzzzzz", 1'b1);
    settle();
    set_mode(1, 1'b1);
    send_text("5", 1'b1);
    settle();
    set_mode(63, 1'b0);
    send_text(" -", 1'b1);
    settle();

    foreach (radix_plan[p]) begin
      r = radix_plan[p];
      if (r == PICK_VALID) r = $urandom_range(3, 35);
      else if (r == PICK_INVALID) r = $urandom_range(37, 62);
      sg = (p % 3 != 1);
      set_mode(r, sg);
      target = (r == 1 || r > txt2i64_pkg::BASE_MAX) ? BAD_PHASE_BYTES : PHASE_BYTES;
      start_count = bytes_queued;
      while (bytes_queued - start_count < target) begin
        add_random_string();
        // In one phase, mid-run, the sender waits for every result before going on.
        if (p == 5 && bytes_queued - start_count >= target / 2 &&
            bytes_queued - start_count < target / 2 + 8)
          settle();
      end
      settle();
    end

    $display("run covered %0d bytes and %0d checked results over %0d register writes",
             bytes_taken, results_seen, writes_done);
    $display("receiver held off %0d times; %0d mismatches seen", holds_done, fail_count);
    if (fail_count == 0) begin
      $display("** integer_text_to_int64_parser: PASSED **");
    end else begin
      $display("** integer_text_to_int64_parser: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/txt2i64_pkg.sv
hw/rtl/txt2i64_front.sv
hw/rtl/txt2i64_back.sv
hw/rtl/txt2i64_finish.sv
hw/rtl/integer_text_to_int64_parser.sv
hw/rtl/txt2i64_checker.sv
tb/tb.sv
